>>> rtl/core/mo_query_order_walker_top_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the Mo-order query walker
// Concurrent checks that can be compiled out with ASSERT_OFF.
// ----------------------------------------------------------------------------
`ifndef MO_QUERY_ORDER_WALKER_TOP_DEFINES_SVH
`define MO_QUERY_ORDER_WALKER_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
// clocked check, off while reset is asserted
`define MOW_ASSERT(lbl, clk_i, rst_n_i, prop) \
	lbl: assert property (@(posedge clk_i) disable iff (!rst_n_i) prop) \
		else $error("mow assertion failed");
// clocked check, also during reset
`define MOW_ASSERT_ALWAYS(lbl, clk_i, prop) \
	lbl: assert property (@(posedge clk_i) prop) else $error("mow assertion failed");
`else
`define MOW_ASSERT(lbl, clk_i, rst_n_i, prop)
`define MOW_ASSERT_ALWAYS(lbl, clk_i, prop)
`endif

`endif

>>> rtl/core/mow_pkg.sv
// ----------------------------------------------------------------------------
// mow_pkg
// Types and constants shared by the Mo-order query walker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package mow_pkg;

	localparam int MAX_N = 1024;
	localparam int MAX_Q = 256;
	localparam int BW    = 11;                 // bound / block width bits
	localparam int EW    = $clog2(MAX_N);      // element index bits
	localparam int QW    = $clog2(MAX_Q);      // query id / table address bits
	localparam int CW    = QW + 1;             // count bits
	localparam int NW    = EW + 1;             // clear counter bits

	localparam logic [BW-1:0] BOUND_MAX = BW'(MAX_N);
	localparam logic [3:0]    DIV_STEPS = 4'(BW);
	localparam logic          CMD_LOAD  = 1'b0;
	localparam logic          CMD_STEP  = 1'b1;

	typedef enum logic [1:0] {
		EV_ADD    = 2'd0,
		EV_DEL    = 2'd1,
		EV_REPORT = 2'd2,
		EV_FIN    = 2'd3
	} ev_kind_t;

	typedef struct packed {
		logic          cmd;
		logic [BW-1:0] left_bound;
		logic [BW-1:0] right_bound;
	} req_t;

	typedef struct packed {
		logic [1:0]    event_kind;
		logic [EW-1:0] element_index;
		logic [QW-1:0] query_id;
	} rsp_t;

	typedef struct packed {
		logic [BW-1:0] left;
		logic [BW-1:0] right;
		logic [QW-1:0] id;
	} entry_t;

	typedef struct packed {
		logic          busy;
		logic [BW-1:0] quotient;
	} div_stat_t;

	typedef enum logic [3:0] {
		ST_CLR,
		ST_IDLE,
		ST_DIV_GO,
		ST_DIV,
		ST_MUL,
		ST_SRD,
		ST_SCMP,
		ST_MRD,
		ST_MWR,
		ST_INS,
		ST_WRD,
		ST_WDEC,
		ST_TRD,
		ST_TWR,
		ST_EMIT
	} state_t;

endpackage
`default_nettype wire

>>> rtl/core/mow_ram.sv
// ----------------------------------------------------------------------------
// mow_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module mow_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

>>> rtl/core/mow_div.sv
// ----------------------------------------------------------------------------
// mow_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module mow_div import mow_pkg::*; (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic [BW-1:0] dividend,
	input  wire logic [BW-1:0] divisor,
	output div_stat_t          stat
);

	logic          busy_q;
	logic [3:0]    cnt_q;
	logic [BW-1:0] rem_q;
	logic [BW-1:0] quo_q;
	logic [BW:0]   shifted;
	logic [BW:0]   trial;
	logic          fits;

	assign shifted = {rem_q, quo_q[BW-1]};
	assign trial   = shifted - {1'b0, divisor};
	assign fits    = (shifted >= {1'b0, divisor});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= DIV_STEPS;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 4'd1;
			if (cnt_q == 4'd1) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= fits ? trial[BW-1:0] : shifted[BW-1:0];
			quo_q <= {quo_q[BW-2:0], fits};
		end
	end

	assign stat.busy     = busy_q;
	assign stat.quotient = quo_q;

endmodule
`default_nettype wire

>>> rtl/core/mo_query_order_walker_top.sv
// ----------------------------------------------------------------------------
// mo_query_order_walker_top
// Mo-order query table with a step-by-step window walk.
// ----------------------------------------------------------------------------
// Usage:
//   req channel (req_valid/req_stall/req): cmd 0 loads a [left, right) query,
//   cmd 1 asks for one walk event. rsp channel (rsp_valid/rsp_stall/rsp)
//   returns one transaction per step: add, delete, report or finished. Loads
//   return nothing. cfg (cfg_valid/cfg_ready/cfg_data) writes block_width;
//   always ready. The user must write it only while idle; not enforced.
// Sequencing (one item in flight, req_stall high while busy):
//   load   : the 11-step divider plus setup, then a scan of the table entries
//            and a move of each later entry up by one for the insert.
//   step   : finished goes straight out; report does a table read and decode;
//            add/delete add a membership read-modify-write after those.
// Reset: a clearing pass walks the 1024-entry membership RAM, one bit per
//   cycle; req_stall stays high until the pass is done.
// Receiver stall: the result sits in the output register; a new request can
//   still be accepted, and a step waits in its final state until the
//   register frees up.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "mo_query_order_walker_top_defines.svh"
module mo_query_order_walker_top import mow_pkg::*; (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output logic               req_stall,
	input  wire req_t          req,
	output logic               rsp_valid,
	input  wire logic          rsp_stall,
	output rsp_t               rsp,
	input  wire logic          cfg_valid,
	output logic               cfg_ready,
	input  wire logic [BW-1:0] cfg_data
);

	state_t state_q, state_d;

	// configuration and control state
	logic [BW-1:0] bw_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] cursor_q;
	logic [BW-1:0] wl_q;
	logic [BW-1:0] wr_q;
	logic [NW-1:0] clr_q;
	logic          out_valid_q;
	rsp_t          out_q;

	// per-item working registers
	logic [BW-1:0] ld_l_q;
	logic [BW-1:0] ld_r_q;
	logic [BW:0]   lo_q;
	logic          par_q;
	logic [CW-1:0] pos_q;
	logic [CW-1:0] idx_q;
	ev_kind_t      kind_q;
	logic [EW-1:0] elem_q;
	logic [QW-1:0] qid_q;

	logic [BW-1:0] w_eff;
	logic          accept;
	logic          is_step;
	logic          walk_done;
	logic          out_free;
	logic [BW:0]   hi;
	logic          precedes;
	entry_t        q_rd;
	logic          m_rd;

	// RAM and divider controls
	logic          q_we;
	logic [QW-1:0] q_waddr;
	entry_t        q_wdata;
	logic [QW-1:0] q_raddr;
	logic          m_we;
	logic [EW-1:0] m_waddr;
	logic          m_wdata;
	logic [EW-1:0] m_raddr;
	logic          div_start;
	logic          emit;
	div_stat_t     div_stat;

	assign w_eff     = (bw_q == '0) ? BW'(1) : bw_q;
	assign req_stall = (state_q != ST_IDLE);
	assign accept    = req_valid && !req_stall;
	assign is_step   = (req.cmd == CMD_STEP);
	assign walk_done = (cursor_q >= count_q);
	assign out_free  = !out_valid_q || !rsp_stall;
	assign cfg_ready = 1'b1;

	// Mo order: block compare through [lo, hi) of the new query's block
	assign hi = lo_q + {1'b0, w_eff};
	always_comb begin
		if ({1'b0, q_rd.left} < lo_q) begin
			precedes = 1'b0;
		end else if ({1'b0, q_rd.left} >= hi) begin
			precedes = 1'b1;
		end else if (par_q) begin
			precedes = (ld_r_q < q_rd.right);
		end else begin
			precedes = (ld_r_q > q_rd.right);
		end
	end

	mow_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (ld_l_q),
		.divisor  (w_eff),
		.stat     (div_stat)
	);

	mow_ram #(.WIDTH($bits(entry_t)), .DEPTH(MAX_Q)) u_qram (
		.clk   (clk),
		.we    (q_we),
		.waddr (q_waddr),
		.wdata (q_wdata),
		.raddr (q_raddr),
		.rdata (q_rd)
	);

	mow_ram #(.WIDTH(1), .DEPTH(MAX_N)) u_mram (
		.clk   (clk),
		.we    (m_we),
		.waddr (m_waddr),
		.wdata (m_wdata),
		.raddr (m_raddr),
		.rdata (m_rd)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLR: begin
				if (clr_q == NW'(MAX_N - 1)) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (accept) begin
					if (is_step) begin
						state_d = walk_done ? ST_EMIT : ST_WRD;
					end else if (count_q < CW'(MAX_Q)) begin
						state_d = ST_DIV_GO;
					end
				end
			end
			ST_DIV_GO: state_d = ST_DIV;
			ST_DIV: begin
				if (!div_stat.busy) state_d = ST_MUL;
			end
			ST_MUL:  state_d = ST_SRD;
			ST_SRD:  state_d = (pos_q == count_q) ? ST_MRD : ST_SCMP;
			ST_SCMP: state_d = precedes ? ST_MRD : ST_SRD;
			ST_MRD:  state_d = (idx_q == pos_q) ? ST_INS : ST_MWR;
			ST_MWR:  state_d = ST_MRD;
			ST_INS:  state_d = ST_IDLE;
			ST_WRD:  state_d = ST_WDEC;
			ST_WDEC: begin
				if (wl_q == q_rd.left && wr_q == q_rd.right) state_d = ST_EMIT;
				else state_d = ST_TRD;
			end
			ST_TRD:  state_d = ST_TWR;
			ST_TWR:  state_d = ST_EMIT;
			ST_EMIT: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		q_we      = 1'b0;
		q_waddr   = pos_q[QW-1:0];
		q_wdata   = q_rd;
		q_raddr   = pos_q[QW-1:0];
		m_we      = 1'b0;
		m_waddr   = elem_q;
		m_wdata   = !m_rd;
		m_raddr   = elem_q;
		div_start = 1'b0;
		emit      = 1'b0;
		case (state_q)
			ST_CLR: begin
				m_we    = 1'b1;
				m_waddr = clr_q[EW-1:0];
				m_wdata = 1'b0;
			end
			ST_DIV_GO: div_start = 1'b1;
			ST_MRD:    q_raddr = QW'(idx_q - CW'(1));
			ST_MWR: begin
				q_we    = 1'b1;
				q_waddr = idx_q[QW-1:0];
			end
			ST_INS: begin
				q_we    = 1'b1;
				q_wdata = '{left: ld_l_q, right: ld_r_q, id: count_q[QW-1:0]};
			end
			ST_WRD:  q_raddr = cursor_q[QW-1:0];
			ST_TWR:  m_we = 1'b1;
			ST_EMIT: emit = out_free;
			default: ;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLR;
			bw_q        <= BW'(32);
			count_q     <= '0;
			cursor_q    <= '0;
			wl_q        <= '0;
			wr_q        <= '0;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) bw_q <= cfg_data;
			if (state_q == ST_CLR) clr_q <= clr_q + NW'(1);
			if (state_q == ST_INS) count_q <= count_q + CW'(1);
			if (state_q == ST_WDEC) begin
				if (wl_q > q_rd.left) begin
					wl_q <= wl_q - BW'(1);
				end else if (wr_q < q_rd.right) begin
					wr_q <= wr_q + BW'(1);
				end else if (wl_q < q_rd.left) begin
					wl_q <= wl_q + BW'(1);
				end else if (wr_q > q_rd.right) begin
					wr_q <= wr_q - BW'(1);
				end else begin
					cursor_q <= cursor_q + CW'(1);
				end
			end
			if (emit) out_valid_q <= 1'b1;
			else if (!rsp_stall) out_valid_q <= 1'b0;
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				ld_l_q <= (req.left_bound > BOUND_MAX) ? BOUND_MAX : req.left_bound;
				ld_r_q <= (req.right_bound > BOUND_MAX) ? BOUND_MAX : req.right_bound;
				pos_q  <= '0;
				kind_q <= EV_FIN;
				elem_q <= '0;
				qid_q  <= '0;
			end
			ST_MUL: begin
				lo_q  <= (BW + 1)'(div_stat.quotient * w_eff);
				par_q <= div_stat.quotient[0];
			end
			ST_SRD: idx_q <= count_q;
			ST_SCMP: begin
				if (!precedes) pos_q <= pos_q + CW'(1);
			end
			ST_MWR: idx_q <= idx_q - CW'(1);
			ST_WDEC: begin
				if (wl_q > q_rd.left) begin
					elem_q <= EW'(wl_q - BW'(1));
				end else if (wr_q < q_rd.right) begin
					elem_q <= wr_q[EW-1:0];
				end else if (wl_q < q_rd.left) begin
					elem_q <= wl_q[EW-1:0];
				end else if (wr_q > q_rd.right) begin
					elem_q <= EW'(wr_q - BW'(1));
				end else begin
					kind_q <= EV_REPORT;
					qid_q  <= q_rd.id;
				end
			end
			ST_TWR: kind_q <= m_rd ? EV_DEL : EV_ADD;
			default: ;
		endcase
		if (emit) begin
			out_q.event_kind    <= kind_q;
			out_q.element_index <= (kind_q == EV_ADD || kind_q == EV_DEL) ? elem_q : '0;
			out_q.query_id      <= qid_q;
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

	// ------------------------------------------------------------------------
	// assertions
	// ------------------------------------------------------------------------
	`MOW_ASSERT(a_count_cap, clk, arst_n, count_q <= CW'(MAX_Q))
	`MOW_ASSERT(a_full_load_ignored, clk, arst_n,
		(accept && !is_step && count_q == CW'(MAX_Q)) |=> (count_q == CW'(MAX_Q)))
	`MOW_ASSERT(a_emit_lands, clk, arst_n, emit |=> rsp_valid)
	`MOW_ASSERT(a_cursor_report, clk, arst_n,
		(state_q == ST_WDEC && state_d == ST_EMIT) |=> (cursor_q == $past(cursor_q) + CW'(1)))

endmodule
`default_nettype wire

>>> tb/sv/tb_mo_query_order_walker_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for mo_query_order_walker_top
// Loads range queries and steps the window walk while both channels idle and
// stall at random. A scoreboard keeps its own Mo-ordered table, window and
// membership bits, and checks each walk event field by field.
// ----------------------------------------------------------------------------

import mow_pkg::*;

// Mirror of the walker: the sorted query table, the window and the expected events.
class mo_walk_scoreboard;

	logic [BW-1:0] tbl_left [MAX_Q];
	logic [BW-1:0] tbl_right[MAX_Q];
	logic [QW-1:0] tbl_id   [MAX_Q];
	bit            in_window[MAX_N];
	int unsigned   n_queries, cursor, win_lo, win_hi;
	logic [BW-1:0] blk_width;
	rsp_t          pending_events[$];
	int            n_errors;
	int            n_events;

	function new();
		blk_width = 11'd32;
		n_queries = 0;
		cursor = 0;
		win_lo = 0;
		win_hi = 0;
		n_errors = 0;
		n_events = 0;
		foreach (in_window[i]) in_window[i] = 1'b0;
	endfunction

	function bit walk_done();
		return cursor >= n_queries;
	endfunction

	function bit goes_first(int unsigned la, int unsigned ra, int unsigned lb,
			int unsigned rb);
		int unsigned w, ba, bb;
		w  = (blk_width == 0) ? 1 : blk_width;
		ba = la / w;
		bb = lb / w;
		if (ba != bb) return ba < bb;
		if (ba[0]) return ra < rb;
		return ra > rb;
	endfunction

	function ev_kind_t flip(int unsigned idx);
		if (idx >= MAX_N) return EV_DEL;
		in_window[idx] = !in_window[idx];
		return in_window[idx] ? EV_ADD : EV_DEL;
	endfunction

	function void insert_query(int unsigned l, int unsigned r);
		int unsigned pos;
		if (n_queries >= MAX_Q) return;            // table full: dropped
		if (l > MAX_N) l = MAX_N;
		if (r > MAX_N) r = MAX_N;
		pos = 0;
		while (pos < n_queries && !goes_first(l, r, tbl_left[pos], tbl_right[pos]))
			pos++;
		for (int unsigned i = n_queries; i > pos; i--) begin
			tbl_left[i]  = tbl_left[i-1];
			tbl_right[i] = tbl_right[i-1];
			tbl_id[i]    = tbl_id[i-1];
		end
		tbl_left[pos]  = BW'(l);
		tbl_right[pos] = BW'(r);
		tbl_id[pos]    = QW'(n_queries);
		n_queries++;
	endfunction

	// Called for each accepted request transaction.
	function void note_request(req_t r);
		rsp_t e;
		int unsigned l, rr;
		if (r.cmd == CMD_LOAD) begin
			insert_query(r.left_bound, r.right_bound);
			return;
		end
		e = '0;
		e.event_kind = EV_FIN;
		if (cursor < n_queries) begin
			l  = tbl_left[cursor];
			rr = tbl_right[cursor];
			if (win_lo > l) begin
				win_lo--;
				e.element_index = EW'(win_lo);
				e.event_kind = flip(win_lo);
			end else if (win_hi < rr) begin
				e.element_index = EW'(win_hi);
				e.event_kind = flip(win_hi);
				win_hi++;
			end else if (win_lo < l) begin
				e.element_index = EW'(win_lo);
				e.event_kind = flip(win_lo);
				win_lo++;
			end else if (win_hi > rr) begin
				win_hi--;
				e.element_index = EW'(win_hi);
				e.event_kind = flip(win_hi);
			end else begin
				e.event_kind = EV_REPORT;
				e.query_id = tbl_id[cursor];
				cursor++;
			end
		end
		pending_events.insert(pending_events.size(), e);
	endfunction

	// Called for each accepted response transaction.
	function void check_event(rsp_t a);
		rsp_t e;
		n_events++;
		if (pending_events.size() == 0) begin
			$error("unexpected response kind=%0d elem=%0d id=%0d",
				a.event_kind, a.element_index, a.query_id);
			n_errors++;
			return;
		end
		e = pending_events.pop_front();
		if (a.event_kind !== e.event_kind) begin
			$error("event_kind expected %0d actual %0d", e.event_kind, a.event_kind);
			n_errors++;
		end
		if (a.element_index !== e.element_index) begin
			$error("element_index expected %0d actual %0d",
				e.element_index, a.element_index);
			n_errors++;
		end
		if (a.query_id !== e.query_id) begin
			$error("query_id expected %0d actual %0d", e.query_id, a.query_id);
			n_errors++;
		end
	endfunction
endclass

module tb_mo_query_order_walker_top;
	import mow_pkg::*;

	localparam int  CYCLE_LIMIT   = 6000000;
	// worst load: divider plus scan and shift over a full table
	localparam int  DRAIN_CYCLES  = 1200;
	// steps per block-width phase before moving on
	localparam int  PHASE_STEPS   = 80;
	localparam int  ITEM_TARGET   = 1500;

	logic          clk = 1'b0;
	logic          arst_n = 1'b0;
	logic          req_valid = 1'b0;
	logic          req_stall;
	req_t          req = '0;
	logic          rsp_valid;
	logic          rsp_stall = 1'b0;
	rsp_t          rsp;
	logic          cfg_valid = 1'b0;
	logic          cfg_ready;
	logic [BW-1:0] cfg_data = '0;

	mo_walk_scoreboard sb;
	int unsigned cycles = 0;
	int          n_sent = 0;
	int          n_loads = 0;
	int          n_cfg = 0;
	int          stall_left = 0;
	bit          quiet_rx = 1'b0;          // receiver draws no new stall, sender no gap, while set

	always #5 clk = ~clk;

	mo_query_order_walker_top u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	// Watchdog.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// Response side: check at the rising edge, redraw the stall at the falling one.
	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall) begin
			sb.check_event(rsp);
			stall_left = quiet_rx ? 0 : $urandom_range(0, 7);
		end
	end

	always @(negedge clk) begin
		if (stall_left > 0) begin
			rsp_stall = 1'b1;
			stall_left--;
		end else begin
			rsp_stall = 1'b0;
		end
	end

	// One request transaction; valid stays high straight into the next one
	// when no gap is drawn.
	task automatic send_req(input logic c, input int unsigned l, input int unsigned r);
		int gap;
		gap = quiet_rx ? 0 : $urandom_range(0, 7);
		if (gap > 0) begin
			req_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		req.cmd = c;
		req.left_bound = BW'(l);
		req.right_bound = BW'(r);
		req_valid = 1'b1;
		do @(posedge clk); while (req_stall);
		sb.note_request(req);
		n_sent++;
		if (c == CMD_LOAD) n_loads++;
		@(negedge clk);
	endtask

	task automatic load_query(input int unsigned l, input int unsigned r);
		send_req(CMD_LOAD, l, r);
	endtask

	task automatic step_walk();
		send_req(CMD_STEP, $urandom_range(0, 2047), $urandom_range(0, 2047));
	endtask

	// Hold off until every event is back, then let a trailing load finish.
	task automatic wait_idle();
		req_valid = 1'b0;
		while (sb.pending_events.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_block_width(input logic [BW-1:0] w);
		wait_idle();
		cfg_data = w;
		cfg_valid = 1'b1;
		do @(posedge clk); while (!cfg_ready);
		sb.blk_width = w;
		n_cfg++;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// Mostly short ranges from a random start; now and then anything at all,
	// including bounds past MAX_N and left above right.
	task automatic load_random();
		int unsigned c, l, r;
		case ($urandom_range(0, 9))
			0: begin
				l = $urandom_range(0, 2047);
				r = $urandom_range(0, 2047);
			end
			1: begin
				l = $urandom_range(0, 1023);
				r = (l > 8) ? l - $urandom_range(1, 8) : l;
			end
			default: begin
				c = $urandom_range(0, 160);
				l = c;
				r = c + $urandom_range(0, 24);
			end
		endcase
		load_query(l, r);
	endtask

	int unsigned n_steps;
	int unsigned blk_choice[] = '{1, 1024, 0, 2047, 3, 16, 31, 64, 7, 100};

	initial begin
		sb = new();
		repeat (2) @(negedge clk);
		arst_n = 1'b1;

		// Directed: extremes of the bounds, left above right, clamping, finished
		// on an empty table, and the start of a walk over them.
		step_walk();
		load_query(0, 0);
		load_query(2047, 2047);
		load_query(1024, 1023);
		load_query(12, 3);
		load_query(1023, 1024);
		load_query(5, 5);
		load_query(0, 40);
		repeat (12) step_walk();
		// Several phases with the sender held off until the walk catches up.
		foreach (blk_choice[k]) begin
			write_block_width(BW'(blk_choice[k]));
			quiet_rx = (k % 3 == 2);
			repeat ($urandom_range(2, 6)) load_random();
			n_steps = 0;
			while (!sb.walk_done() && n_steps < PHASE_STEPS) begin
				step_walk();
				n_steps++;
			end
			step_walk();
		end

		// Random: batches of loads followed by a run of steps; once the
		// table is full the loads are dropped and only the walk remains.
		quiet_rx = 1'b0;
		while (n_sent < ITEM_TARGET) begin
			if ($urandom_range(0, 19) == 0) quiet_rx = !quiet_rx;
			if ($urandom_range(0, 3) == 0) begin
				repeat ($urandom_range(1, 4)) load_random();
			end
			n_steps = $urandom_range(1, 60);
			repeat (n_steps) step_walk();
			if ($urandom_range(0, 99) == 0)
				write_block_width(BW'($urandom_range(1, 1024)));
		end
		repeat (3) step_walk();

		wait_idle();
		$display("Covered %0d requests (%0d loads, %0d queries kept), %0d events,",
			n_sent, n_loads, sb.n_queries, sb.n_events);
		$display("%0d block width settings.", n_cfg);
		if (sb.n_errors == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

>>> files.f
+incdir+rtl/core
rtl/core/mow_pkg.sv
rtl/core/mow_ram.sv
rtl/core/mow_div.sv
rtl/core/mo_query_order_walker_top.sv
tb/sv/tb_mo_query_order_walker_top.sv
